>>> rtl/core/elgamal_char_cipher_top_macros.svh
// ----------------------------------------------------------------------------
// elgamal_char_cipher_top_macros.svh
// Assertion macros shared by the cipher core modules.
// ----------------------------------------------------------------------------
`ifndef ELGAMAL_CHAR_CIPHER_TOP_MACROS_SVH
`define ELGAMAL_CHAR_CIPHER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define EGCC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("egcc assertion failed");

// Next-cycle implication, checked outside reset
`define EGCC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("egcc assertion failed");

`endif

>>> rtl/core/egcc_pkg.sv
// ----------------------------------------------------------------------------
// egcc_pkg
// Shared widths and types for the ElGamal character cipher core.
// ----------------------------------------------------------------------------
package egcc_pkg;

   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(WORD_BITS);
   localparam int IDX_BITS  = 2;

   // Configuration register indexes
   localparam logic [IDX_BITS-1:0] REG_MODULUS     = 2'd0;
   localparam logic [IDX_BITS-1:0] REG_GENERATOR   = 2'd1;
   localparam logic [IDX_BITS-1:0] REG_PUBLIC_KEY  = 2'd2;
   localparam logic [IDX_BITS-1:0] REG_PRIVATE_KEY = 2'd3;

   // Status of the shared modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

endpackage

>>> rtl/core/egcc_modmul.sv
// ----------------------------------------------------------------------------
// egcc_modmul
// Bit-serial interleaved modular multiplier: product = op_a * op_b mod p.
// op_b must be below the modulus; op_a may be any word. One bit per cycle,
// every bit of op_a in turn from the top, a one-cycle done pulse at the end.
// ----------------------------------------------------------------------------
`include "elgamal_char_cipher_top_macros.svh"

module egcc_modmul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [egcc_pkg::WORD_BITS-1:0] op_a,
   input  logic [egcc_pkg::WORD_BITS-1:0] op_b,
   input  logic [egcc_pkg::WORD_BITS-1:0] modulus,
   output logic [egcc_pkg::WORD_BITS-1:0] product,
   output egcc_pkg::mm_stat_type          stat
);
   import egcc_pkg::*;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   logic [WORD_BITS-1:0] a_ff, a_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] r_ff, r_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [WORD_BITS:0] mod_ext;
   logic [WORD_BITS:0] dbl, dbl_red, sum, sum_red;

   // One step: r = 2r mod p, then r = r + bit*b mod p
   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
      sum     = dbl_red + (a_ff[WORD_BITS-1] ? {1'b0, b_ff} : '0);
      sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
   end

   // Sequencing of the bit steps
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = op_a;
         b_in    = op_b;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {a_ff[WORD_BITS-2:0], 1'b0};
         r_in   = sum_red[WORD_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign product   = r_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `EGCC_ASSERT_NEXT(a_start_busy, start, busy_ff)
   `EGCC_ASSERT_NEXT(a_done_pulse, done_ff, !done_ff)
   `EGCC_ASSERT_NEXT(a_last_done, busy_ff && !start && cnt_ff == CNT_LAST, done_ff && !busy_ff)

endmodule

>>> rtl/core/elgamal_char_cipher_top.sv
// ----------------------------------------------------------------------------
// elgamal_char_cipher_top
// ElGamal encrypt/decrypt of one character per transaction, built around a
// single bit-serial modular multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// One transaction at a time: req_tready is high only while idle. Every modular
// product goes through the shared multiplier. An exponentiation costs one
// reduction plus one squaring per exponent bit up to its top set bit, plus one
// product per set bit: at most about 65 products. Encrypt runs two
// exponentiations by k and one product; decrypt runs one by x, one by p-2
// unless the shared secret is zero, and one product. A modulus below two
// returns all zeros. Registers may be written only while the block is idle.
`include "elgamal_char_cipher_top_macros.svh"

module elgamal_char_cipher_top (
   input  logic                            clock,
   input  logic                            reset,
   // Request: tdata = message[7:0], random_k[39:8], cipher_a[71:40],
   //          cipher_b[103:72]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [103:0]                    req_tdata,
   input  logic                            req_tuser,   // kind: 0 encrypt, 1 decrypt
   // Response: tdata = out_a[31:0], out_b[63:32], recovered[95:64]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [95:0]                     rsp_tdata,
   // Register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [egcc_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [egcc_pkg::WORD_BITS-1:0]  csr_data
);
   import egcc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RED  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_SQR  = 6'b001000,
      ST_FIN  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      PH_GK  = 2'd0,   // g^k
      PH_YK  = 2'd1,   // y^k
      PH_AX  = 2'd2,   // a^x
      PH_INV = 2'd3    // s^(p-2)
   } phase_type;

   localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

   // Configuration registers
   logic [WORD_BITS-1:0] modulus_ff, generator_ff, public_key_ff, private_key_ff;

   state_type            state_ff, state_in;
   phase_type            phase_ff, phase_in;
   logic                 launched_ff, launched_in;
   logic                 kind_ff, kind_in;
   logic [7:0]           msg_ff, msg_in;
   logic [WORD_BITS-1:0] k_ff, k_in;
   logic [WORD_BITS-1:0] cb_ff, cb_in;
   logic [WORD_BITS-1:0] base_ff, base_in;
   logic [WORD_BITS-1:0] exp_ff, exp_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] sq_ff, sq_in;
   logic [WORD_BITS-1:0] fin_a_ff, fin_a_in;
   logic [WORD_BITS-1:0] fin_b_ff, fin_b_in;
   logic [WORD_BITS-1:0] out_a_ff, out_a_in;
   logic [WORD_BITS-1:0] out_b_ff, out_b_in;
   logic [WORD_BITS-1:0] rec_ff, rec_in;

   logic                 mm_start;
   logic [WORD_BITS-1:0] mm_a, mm_b, mm_product;
   mm_stat_type          mm_stat;
   logic                 req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= WORD_BITS'(3);
         generator_ff   <= WORD_BITS'(2);
         public_key_ff  <= WORD_BITS'(1);
         private_key_ff <= WORD_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MODULUS:     modulus_ff     <= csr_data;
            REG_GENERATOR:   generator_ff   <= csr_data;
            REG_PUBLIC_KEY:  public_key_ff  <= csr_data;
            REG_PRIVATE_KEY: private_key_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Multiplier launch and operand select
   always_comb begin
      mm_start = 1'b0;
      mm_a     = acc_ff;
      mm_b     = sq_ff;
      case (state_ff)
         ST_RED: begin
            mm_start = !launched_ff;
            mm_a     = base_ff;
            mm_b     = ONE;
         end
         ST_MUL: begin
            mm_start = !launched_ff && (exp_ff != '0) && exp_ff[0];
         end
         ST_SQR: begin
            mm_start = !launched_ff;
            mm_a     = sq_ff;
         end
         ST_FIN: begin
            mm_start = !launched_ff;
            mm_a     = fin_a_ff;
            mm_b     = fin_b_ff;
         end
         default: ;
      endcase
   end

   egcc_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (modulus_ff),
      .product (mm_product),
      .stat    (mm_stat)
   );

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      launched_in = launched_ff;
      kind_in     = kind_ff;
      msg_in      = msg_ff;
      k_in        = k_ff;
      cb_in       = cb_ff;
      base_in     = base_ff;
      exp_in      = exp_ff;
      acc_in      = acc_ff;
      sq_in       = sq_ff;
      fin_a_in    = fin_a_ff;
      fin_b_in    = fin_b_ff;
      out_a_in    = out_a_ff;
      out_b_in    = out_b_ff;
      rec_in      = rec_ff;

      if (mm_start) launched_in = 1'b1;
      if (mm_stat.done) launched_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               msg_in   = req_tdata[7:0];
               k_in     = req_tdata[39:8];
               cb_in    = req_tdata[103:72];
               out_a_in = '0;
               out_b_in = '0;
               rec_in   = '0;
               if (modulus_ff < WORD_BITS'(2)) begin
                  state_in = ST_OUT;
               end else if (!req_tuser) begin
                  phase_in = PH_GK;
                  base_in  = generator_ff;
                  exp_in   = req_tdata[39:8];
                  state_in = ST_RED;
               end else begin
                  phase_in = PH_AX;
                  base_in  = req_tdata[71:40];
                  exp_in   = private_key_ff;
                  state_in = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (mm_stat.done) begin
               sq_in    = mm_product;
               acc_in   = ONE;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (exp_ff == '0) begin
               // exponentiation complete, result in acc
               case (phase_ff)
                  PH_GK: begin
                     out_a_in = acc_ff;
                     phase_in = PH_YK;
                     base_in  = public_key_ff;
                     exp_in   = k_ff;
                     state_in = ST_RED;
                  end
                  PH_YK: begin
                     fin_a_in = {{(WORD_BITS-8){1'b0}}, msg_ff};
                     fin_b_in = acc_ff;
                     state_in = ST_FIN;
                  end
                  PH_AX: begin
                     if (acc_ff == '0) begin
                        // zero shared secret: inverse taken as one
                        fin_a_in = cb_ff;
                        fin_b_in = ONE;
                        state_in = ST_FIN;
                     end else begin
                        phase_in = PH_INV;
                        base_in  = acc_ff;
                        exp_in   = modulus_ff - WORD_BITS'(2);
                        state_in = ST_RED;
                     end
                  end
                  PH_INV: begin
                     fin_a_in = cb_ff;
                     fin_b_in = acc_ff;
                     state_in = ST_FIN;
                  end
                  default: ;
               endcase
            end else if (!exp_ff[0]) begin
               state_in = ST_SQR;
            end else if (mm_stat.done) begin
               acc_in   = mm_product;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mm_stat.done) begin
               sq_in    = mm_product;
               exp_in   = exp_ff >> 1;
               state_in = ST_MUL;
            end
         end
         ST_FIN: begin
            if (mm_stat.done) begin
               if (kind_ff) rec_in = mm_product;
               else         out_b_in = mm_product;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_GK;
         launched_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         launched_ff <= launched_in;
      end
      kind_ff  <= kind_in;
      msg_ff   <= msg_in;
      k_ff     <= k_in;
      cb_ff    <= cb_in;
      base_ff  <= base_in;
      exp_ff   <= exp_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
      fin_a_ff <= fin_a_in;
      fin_b_ff <= fin_b_in;
      out_a_ff <= out_a_in;
      out_b_ff <= out_b_in;
      rec_ff   <= rec_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {rec_ff, out_b_ff, out_a_ff};

   `EGCC_ASSERT_NOW(a_rsp_blocks_req, rsp_tvalid, !req_tready)
   `EGCC_ASSERT_NOW(a_start_when_free, mm_start, !mm_stat.busy)
   `EGCC_ASSERT_NOW(a_idle_mm_quiet, state_ff == ST_IDLE || state_ff == ST_OUT, !mm_stat.busy && !launched_ff)

endmodule

>>> tb/elgamal_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elgamal_checker
// Watches the request, response and register channels of the cipher, keeps a
// private copy of the registers, computes the expected ciphertext or
// plaintext of each accepted request and compares responses in order.
// ----------------------------------------------------------------------------
module elgamal_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [103:0]                    req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [95:0]                     rsp_tdata,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [egcc_pkg::IDX_BITS-1:0]   csr_index,
   input  logic [egcc_pkg::WORD_BITS-1:0]  csr_data,
   output int                              fail_count,
   output int                              pending
);
   import egcc_pkg::*;

   // Lowest bits first in tdata: out_a, out_b, recovered
   typedef struct packed {
      logic [31:0] recovered;
      logic [31:0] out_b;
      logic [31:0] out_a;
   } cipher_result_type;

   logic [31:0] mod_p, gen_g, pub_y, priv_x;
   cipher_result_type result_q[$];

   // Square-and-multiply, products exact in 64 bits
   function automatic logic [31:0] mod_exp(logic [31:0] base, logic [31:0] ex,
                                           logic [31:0] p);
      logic [63:0] acc, sq, pw;
      pw  = 64'(p);
      acc = 64'd1 % pw;
      sq  = 64'(base) % pw;
      for (int i = 0; i < 32; i++) begin
         if (ex[i]) acc = (acc * sq) % pw;
         sq = (sq * sq) % pw;
      end
      return acc[31:0];
   endfunction

   function automatic cipher_result_type cipher_predict(logic kind, logic [103:0] d);
      cipher_result_type r;
      logic [63:0] s, inv, t, pw;
      r  = '0;
      pw = 64'(mod_p);
      if (mod_p != 32'd0) begin
         if (!kind) begin
            r.out_a = mod_exp(gen_g, d[39:8], mod_p);
            t = 64'(mod_exp(pub_y, d[39:8], mod_p));
            t = (t * (64'(d[7:0]) % pw)) % pw;
            r.out_b = t[31:0];
         end else begin
            s = 64'(mod_exp(d[71:40], priv_x, mod_p));
            if (s == 64'd0 || mod_p < 32'd2) inv = 64'd1 % pw;
            else inv = 64'(mod_exp(s[31:0], mod_p - 32'd2, mod_p));
            t = ((64'(d[103:72]) % pw) * inv) % pw;
            r.recovered = t[31:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cipher_result_type got, want;
      if (reset) begin
         mod_p <= 32'd3;
         gen_g <= 32'd2;
         pub_y <= 32'd1;
         priv_x <= 32'd1;
         result_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         // Register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODULUS:     mod_p <= csr_data;
               REG_GENERATOR:   gen_g <= csr_data;
               REG_PUBLIC_KEY:  pub_y <= csr_data;
               REG_PRIVATE_KEY: priv_x <= csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            result_q.insert(result_q.size(), cipher_predict(req_tuser, req_tdata));
         // Response compare
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (result_q.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = result_q.pop_front();
               if (got.out_a !== want.out_a || got.out_b !== want.out_b ||
                   got.recovered !== want.recovered)
                  fail_count <= fail_count + 1;
               if (got.out_a !== want.out_a)
                  $error("out_a expected %h actual %h", want.out_a, got.out_a);
               if (got.out_b !== want.out_b)
                  $error("out_b expected %h actual %h", want.out_b, got.out_b);
               if (got.recovered !== want.recovered)
                  $error("recovered expected %h actual %h", want.recovered,
                         got.recovered);
            end
         end
         pending <= result_q.size();
      end
   end
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives encrypt and decrypt transactions and register settings into the
// ElGamal cipher under random stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import egcc_pkg::*;

   localparam int WATCHDOG = 40000;
   localparam int DRAIN    = 200;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [IDX_BITS-1:0]  csr_index = '0;
   logic [WORD_BITS-1:0] csr_data = '0;
   int           fail_count, pending;
   int           send_idle_pct, recv_idle_pct;
   int           quiet_cycles;

   always #5 clock = ~clock;

   elgamal_char_cipher_top dut (.*);
   elgamal_checker checker_i (.*);

   // Receiver stalls
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic set_keys(logic [31:0] p, logic [31:0] g, logic [31:0] y,
                           logic [31:0] x);
      wait_idle();
      write_reg(REG_MODULUS, p);
      write_reg(REG_GENERATOR, g);
      write_reg(REG_PUBLIC_KEY, y);
      write_reg(REG_PRIVATE_KEY, x);
   endtask

   task automatic send_item(logic kind, logic [7:0] msg, logic [31:0] k,
                            logic [31:0] ca, logic [31:0] cb);
      do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {cb, ca, k, msg};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return $urandom_range(15);
         1: return 32'hFFFF_FFFF - $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   // Random phase with a given key set: alternating encrypt and decrypt
   task automatic random_phase(int n);
      logic [31:0] k;
      for (int i = 0; i < n; i++) begin
         k = rand_word();
         send_item(1'b0, 8'($urandom), k, rand_word(), rand_word());
         send_item(1'b1, 8'($urandom), rand_word(), rand_word(), rand_word());
      end
   endtask

   initial begin
      send_idle_pct = 32;
      recv_idle_pct = 78;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset keys, extremes, both kinds
      send_item(1'b0, 8'h00, 32'd0, 32'd0, 32'd0);
      send_item(1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(1'b1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(1'b1, 8'h00, 32'd0, 32'd0, 32'd5);
      // Zero modulus, modulus one, modulus two
      set_keys(32'd0, 32'd2, 32'd1, 32'd1);
      send_item(1'b0, 8'h41, 32'd7, 32'd0, 32'd0);
      send_item(1'b1, 8'h00, 32'd0, 32'd3, 32'd9);
      set_keys(32'd1, 32'd2, 32'd1, 32'd1);
      send_item(1'b0, 8'h41, 32'd7, 32'd0, 32'd0);
      send_item(1'b1, 8'h00, 32'd0, 32'd3, 32'd9);
      set_keys(32'd2, 32'd1, 32'd1, 32'd1);
      send_item(1'b0, 8'h01, 32'd3, 32'd0, 32'd0);
      send_item(1'b1, 8'h00, 32'd0, 32'd1, 32'd3);
      // Typical prime, zero shared secret, oversized operands
      set_keys(32'd467, 32'd2, 32'd132, 32'd127);
      send_item(1'b0, 8'h48, 32'd213, 32'd0, 32'd0);
      send_item(1'b1, 8'h00, 32'd0, 32'd29, 32'd395);
      send_item(1'b1, 8'h00, 32'd0, 32'd467, 32'd100);
      send_item(1'b1, 8'h00, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // Composite modulus and largest values
      set_keys(32'd1000, 32'd7, 32'd13, 32'd11);
      send_item(1'b0, 8'hA5, 32'd99, 32'd0, 32'd0);
      send_item(1'b1, 8'h00, 32'd0, 32'd77, 32'd3001);
      set_keys(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(1'b0, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
      send_item(1'b1, 8'h00, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
      // Sender holds off until all responses are back
      wait_idle();

      // Random phases with changing idling
      set_keys(32'd2147483647, 32'd7, 32'd16807, $urandom);
      random_phase(20);
      send_idle_pct = 78;
      recv_idle_pct = 32;
      set_keys(32'd65521, 32'd17, $urandom_range(65520), $urandom);
      random_phase(20);
      set_keys($urandom | 32'h8000_0001, $urandom, $urandom, $urandom);
      random_phase(12);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_keys(32'd3, 32'd2, 32'd1, 32'd1);
      random_phase(10);

      wait_idle();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
